// ===== rtl/core/log_block_flash_translation_macros.svh =====
// Assertion macros for the flash translation engine.
// Used by log_block_flash_translation.sv; expects clk and rst_n in scope.
`ifndef LOG_BLOCK_FLASH_TRANSLATION_MACROS_SVH
`define LOG_BLOCK_FLASH_TRANSLATION_MACROS_SVH

// same-cycle implication
`define LBFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LBFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lbft_pkg.sv =====
// Package for the flash translation engine: geometry constants and action codes.
// No dependencies.
`timescale 1ns / 1ps

package lbft_pkg;

  localparam int OFF_W        = 4;
  localparam int PAGES        = 1 << OFF_W;
  localparam int LBN_W        = 6;
  localparam int DATA_BLOCKS  = 1 << LBN_W;
  localparam int BLK_W        = 7;
  localparam int TOTAL_BLOCKS = 1 << BLK_W;
  localparam int SEC_W        = OFF_W + LBN_W;
  localparam int PAGE_W       = BLK_W + OFF_W;
  localparam int CNT_W        = BLK_W + 1;
  localparam int ACT_W        = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ    = 3'd0,
    ACT_PROGRAM = 3'd1,
    ACT_COPY    = 3'd2,
    ACT_ERASE   = 3'd3,
    ACT_UNMAP   = 3'd4,
    ACT_NOTFND  = 3'd5,
    ACT_NOFREE  = 3'd6
  } action_t;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

endpackage

// ===== rtl/core/log_block_flash_translation.sv =====
// Flash translation engine top level: map, free stack, tag memory and sequencer.
// Depends on lbft_pkg and log_block_flash_translation_macros.svh.
`timescale 1ns / 1ps
`include "log_block_flash_translation_macros.svh"

//  channel  | direction | carries
//  in_      | request   | tuser: kind; tdata: sector_number (bits 9:0)
//  out_     | result    | tdata: action, source_page, dest_page, erase_block; tlast: last
//
// A read searches the pages of the mapped block from the newest written one down,
// through the tag memory whose read data is registered. A merge walks all
// pages of the old block, copying each newest live sector; output stalls hold it.
// No clearing pass after reset: the map and free stack use valid bits.
// A stalled output holds the sequencer.

module log_block_flash_translation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sector_number[9:0], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // action[2:0], source_page[13:3], dest_page[24:14],
                                  // erase_block[31:25]
  output logic        out_tlast
);

  localparam int OFF_W  = lbft_pkg::OFF_W;
  localparam int BLK_W  = lbft_pkg::BLK_W;
  localparam int LBN_W  = lbft_pkg::LBN_W;
  localparam int SEC_W  = lbft_pkg::SEC_W;
  localparam int PAGE_W = lbft_pkg::PAGE_W;
  localparam int CNT_W  = lbft_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_RFETCH, S_RCHK, S_MFETCH, S_MCHK, S_MPROG, S_MERASE
  } state_t;

  // memories
  logic [BLK_W-1:0]         map_blk_mem [lbft_pkg::DATA_BLOCKS];
  logic [OFF_W-1:0]         map_off_mem [lbft_pkg::DATA_BLOCKS];
  logic [BLK_W-1:0]         stk_mem     [lbft_pkg::TOTAL_BLOCKS];
  logic [SEC_W-1:0]         tag_mem     [lbft_pkg::TOTAL_BLOCKS * lbft_pkg::PAGES];

  logic [lbft_pkg::DATA_BLOCKS-1:0]  map_valid_r;
  logic [lbft_pkg::TOTAL_BLOCKS-1:0] stk_valid_r;

  state_t               state_r, state_nxt;
  logic                 kind_r;
  logic [SEC_W-1:0]     sec_r;
  logic [BLK_W-1:0]     mblk_q, stk_q, blk_r, blk_nxt, nb_r, nb_nxt;
  logic [OFF_W-1:0]     moff_q, idx_r, idx_nxt, noff_r, noff_nxt;
  logic [SEC_W-1:0]     tag_q;
  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [lbft_pkg::PAGES-1:0] seen_r, seen_nxt;

  logic                 out_valid_r, out_last_r;
  logic [31:0]          out_data_r;

  logic                 in_acc, can_emit;
  logic                 emit_vld, emit_last;
  lbft_pkg::action_t    emit_act;
  logic [PAGE_W-1:0]    emit_src, emit_dst;
  logic [BLK_W-1:0]     emit_erb;
  logic                 tag_we, map_we, set_valid, push;
  logic [PAGE_W-1:0]    tag_wa;
  logic [SEC_W-1:0]     tag_wd;
  logic [BLK_W-1:0]     map_wblk;
  logic [OFF_W-1:0]     map_woff;
  logic [LBN_W-1:0]     lbn;
  logic [BLK_W-1:0]     stk_ra;
  logic                 mvalid;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign can_emit   = !out_valid_r || out_tready;
  assign lbn        = sec_r[SEC_W-1:OFF_W];
  assign mvalid     = map_valid_r[lbn];
  assign stk_ra     = free_cnt_r[BLK_W-1:0] - 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    blk_nxt      = blk_r;
    nb_nxt       = nb_r;
    idx_nxt      = idx_r;
    noff_nxt     = noff_r;
    free_cnt_nxt = free_cnt_r;
    seen_nxt     = seen_r;
    emit_vld     = 1'b0;
    emit_last    = 1'b0;
    emit_act     = lbft_pkg::ACT_READ;
    emit_src     = '0;
    emit_dst     = '0;
    emit_erb     = '0;
    tag_we       = 1'b0;
    tag_wa       = '0;
    tag_wd       = sec_r;
    map_we       = 1'b0;
    map_wblk     = mblk_q;
    map_woff     = '0;
    set_valid    = 1'b0;
    push         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (kind_r == lbft_pkg::KIND_READ && mvalid) begin
          blk_nxt   = mblk_q;
          idx_nxt   = moff_q;
          state_nxt = S_RFETCH;
        end else if (can_emit) begin
          emit_vld  = 1'b1;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
          priority if (kind_r == lbft_pkg::KIND_READ) begin
            emit_act = lbft_pkg::ACT_UNMAP;
          end else if ((!mvalid || moff_q == '1) && free_cnt_r == '0) begin
            emit_act = lbft_pkg::ACT_NOFREE;
          end else if (!mvalid) begin
            emit_act     = lbft_pkg::ACT_PROGRAM;
            emit_dst     = {stk_q, {OFF_W{1'b0}}};
            tag_we       = 1'b1;
            tag_wa       = {stk_q, {OFF_W{1'b0}}};
            map_we       = 1'b1;
            map_wblk     = stk_q;
            set_valid    = 1'b1;
            free_cnt_nxt = free_cnt_r - 1'b1;
          end else if (moff_q == '1) begin
            // full block: start merge, nothing emitted yet
            emit_vld     = 1'b0;
            emit_last    = 1'b0;
            blk_nxt      = mblk_q;
            nb_nxt       = stk_q;
            free_cnt_nxt = free_cnt_r - 1'b1;
            seen_nxt     = lbft_pkg::PAGES'(1) << sec_r[OFF_W-1:0];
            idx_nxt      = '1;
            noff_nxt     = '0;
            state_nxt    = S_MFETCH;
          end else begin
            emit_act = lbft_pkg::ACT_PROGRAM;
            emit_dst = {mblk_q, moff_q + 1'b1};
            tag_we   = 1'b1;
            tag_wa   = {mblk_q, moff_q + 1'b1};
            map_we   = 1'b1;
            map_woff = moff_q + 1'b1;
          end
        end
      end
      S_RFETCH: state_nxt = S_RCHK;
      S_RCHK: begin
        if (tag_q == sec_r) begin
          if (can_emit) begin
            emit_vld  = 1'b1;
            emit_last = 1'b1;
            emit_act  = lbft_pkg::ACT_READ;
            emit_src  = {blk_r, idx_r};
            state_nxt = S_IDLE;
          end
        end else if (idx_r == '0) begin
          if (can_emit) begin
            emit_vld  = 1'b1;
            emit_last = 1'b1;
            emit_act  = lbft_pkg::ACT_NOTFND;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_RFETCH;
        end
      end
      S_MFETCH: state_nxt = S_MCHK;
      S_MCHK: begin
        if (tag_q[SEC_W-1:OFF_W] == lbn && !seen_r[tag_q[OFF_W-1:0]]) begin
          if (can_emit) begin
            emit_vld  = 1'b1;
            emit_act  = lbft_pkg::ACT_COPY;
            emit_src  = {blk_r, idx_r};
            emit_dst  = {nb_r, noff_r};
            tag_we    = 1'b1;
            tag_wa    = {nb_r, noff_r};
            tag_wd    = tag_q;
            seen_nxt  = seen_r | (lbft_pkg::PAGES'(1) << tag_q[OFF_W-1:0]);
            noff_nxt  = noff_r + 1'b1;
            idx_nxt   = idx_r - 1'b1;
            state_nxt = (idx_r == '0) ? S_MPROG : S_MFETCH;
          end
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = (idx_r == '0) ? S_MPROG : S_MFETCH;
        end
      end
      S_MPROG: begin
        if (can_emit) begin
          emit_vld  = 1'b1;
          emit_act  = lbft_pkg::ACT_PROGRAM;
          emit_dst  = {nb_r, noff_r};
          tag_we    = 1'b1;
          tag_wa    = {nb_r, noff_r};
          map_we    = 1'b1;
          map_wblk  = nb_r;
          map_woff  = noff_r;
          state_nxt = S_MERASE;
        end
      end
      S_MERASE: begin
        if (can_emit) begin
          emit_vld     = 1'b1;
          emit_last    = 1'b1;
          emit_act     = lbft_pkg::ACT_ERASE;
          emit_erb     = blk_r;
          push         = 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          seen_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= CNT_W'(lbft_pkg::TOTAL_BLOCKS);
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      map_valid_r <= '0;
      stk_valid_r <= '0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      seen_r     <= seen_nxt;
      if (set_valid) map_valid_r[lbn] <= 1'b1;
      if (push) stk_valid_r[free_cnt_r[BLK_W-1:0]] <= 1'b1;
      if (emit_vld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    blk_r  <= blk_nxt;
    nb_r   <= nb_nxt;
    idx_r  <= idx_nxt;
    noff_r <= noff_nxt;
    if (in_acc) begin
      kind_r <= in_tuser;
      sec_r  <= in_tdata[SEC_W-1:0];
    end
    if (emit_vld) begin
      out_data_r <= {emit_erb, emit_dst, emit_src, emit_act};
      out_last_r <= emit_last;
    end
  end

  // logical block map
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_blk_mem[lbn] <= map_wblk;
      map_off_mem[lbn] <= map_woff;
    end
    if (in_acc) begin
      mblk_q <= map_blk_mem[in_tdata[SEC_W-1:OFF_W]];
      moff_q <= map_off_mem[in_tdata[SEC_W-1:OFF_W]];
    end
  end

  // free stack; an entry never pushed holds its reset block
  always_ff @(posedge clk) begin
    if (push) stk_mem[free_cnt_r[BLK_W-1:0]] <= blk_r;
    stk_q <= stk_valid_r[stk_ra] ? stk_mem[stk_ra]
                                 : BLK_W'(lbft_pkg::TOTAL_BLOCKS - 1) - stk_ra;
  end

  // page tag memory
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_q <= tag_mem[{blk_r, idx_r}];
  end

  `LBFT_ASSERT_NOW(a_free_bound, 1'b1, free_cnt_r <= CNT_W'(lbft_pkg::TOTAL_BLOCKS), "free count overflow")
  `LBFT_ASSERT_NEXT(a_acc_decode, in_acc, state_r == S_DECODE, "accept did not start decode")
  `LBFT_ASSERT_NOW(a_erase_room, state_r == S_MERASE, free_cnt_r < CNT_W'(lbft_pkg::TOTAL_BLOCKS), "push onto full stack")
  `LBFT_ASSERT_NOW(a_merge_seen, state_r == S_MCHK, seen_r != '0, "merge lost new sector mark")

endmodule
